/* hw/rtl/clns_pkg.sv */
package clns_pkg;

  // Request codes on in_cmd
  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_BYTE   = 2'd1;
  localparam logic [1:0] CMD_CHAR   = 2'd2;
  localparam logic [1:0] CMD_CURSOR = 2'd3;

  // Segment timing, microseconds
  localparam logic [15:0] EN_US        = 16'd5;
  localparam logic [15:0] POWERUP_US   = 16'd40000;
  localparam logic [15:0] WAKE_HOLD_US = 16'd205;   // 5 + 200
  localparam logic [15:0] CMD_HOLD_US  = 16'd45;    // 5 + 40
  localparam logic [15:0] DISP_HOLD_US = 16'd2005;  // 5 + 2000
  localparam logic [15:0] ZERO_US      = 16'd0;

  // Sequence lengths, as last step index
  localparam logic [5:0] INIT_LAST_STEP = 6'd36;
  localparam logic [5:0] BYTE_LAST_STEP = 6'd5;
  localparam logic [5:0] CHAR_LAST_STEP = 6'd7;

  // Low nibble left on the bus after init (byte 0x0F)
  localparam logic [3:0] INIT_END_NIBBLE = 4'hF;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_CMD,
    KIND_CHAR
  } kind_t;

  // Classified request handed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } desc_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic        enable;
    logic [15:0] hold_us;
    logic        last;
  } seg_t;

  // One step of a byte transfer: setup, EN high, EN low, per nibble
  function automatic seg_t byte_seg(input logic [2:0] step, input logic [7:0] b, input logic rs);
    seg_t s;
    s.nibble  = (step < 3'd3) ? b[7:4] : b[3:0];
    s.rs      = rs;
    s.enable  = (step == 3'd1) || (step == 3'd4);
    s.hold_us = EN_US;
    s.last    = 1'b0;
    return s;
  endfunction

  // Power-up init sequence, 37 steps
  function automatic seg_t init_seg(input logic [5:0] step);
    seg_t s;
    s.rs   = 1'b0;
    s.last = (step == INIT_LAST_STEP);
    // data lines
    unique case (step) inside
      [6'd1:6'd9]:   s.nibble = 4'h3;
      [6'd10:6'd15]: s.nibble = 4'h2;
      [6'd16:6'd18]: s.nibble = 4'h8;
      [6'd22:6'd24]: s.nibble = 4'hC;
      [6'd28:6'd30]: s.nibble = 4'h6;
      [6'd34:6'd36]: s.nibble = 4'hF;
      default:       s.nibble = 4'h0;
    endcase
    // EN is high in the middle segment of each nibble
    unique case (step)
      6'd2, 6'd5, 6'd8, 6'd11, 6'd14, 6'd17,
      6'd20, 6'd23, 6'd26, 6'd29, 6'd32, 6'd35: s.enable = 1'b1;
      default:                                  s.enable = 1'b0;
    endcase
    // hold times with trailing delays folded in
    unique case (step)
      6'd0:                     s.hold_us = POWERUP_US;
      6'd3, 6'd6, 6'd9:         s.hold_us = WAKE_HOLD_US;
      6'd12, 6'd18, 6'd24, 6'd30: s.hold_us = CMD_HOLD_US;
      6'd36:                    s.hold_us = DISP_HOLD_US;
      default:                  s.hold_us = EN_US;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/clns_front.sv */
module clns_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_value,
  input  logic               in_row,
  input  logic [5:0]         in_column,
  output logic               q_push,
  input  logic               q_full,
  output clns_pkg::desc_t    q_desc
);
  import clns_pkg::*;

  logic  fr_valid_r, fr_valid_nxt;
  desc_t fr_desc_r;
  desc_t cls_desc;
  logic  accept;

  // Classify the request
  always_comb begin
    cls_desc.data_byte = in_value;
    unique case (in_cmd)
      CMD_INIT: begin
        cls_desc.kind      = KIND_INIT;
        cls_desc.data_byte = 8'h00;
      end
      CMD_BYTE:   cls_desc.kind = KIND_CMD;
      CMD_CHAR:   cls_desc.kind = KIND_CHAR;
      CMD_CURSOR: begin
        // set DDRAM address: 0x80 | (row ? 0x40 + col : col), col < 64
        cls_desc.kind      = KIND_CMD;
        cls_desc.data_byte = {1'b1, in_row, in_column};
      end
      default: begin
        cls_desc.kind      = KIND_CMD;
        cls_desc.data_byte = in_value;
      end
    endcase
  end

  // Holding stage ahead of the queue
  assign q_push  = fr_valid_r && !q_full;
  assign in_full = fr_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_desc  = fr_desc_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_desc_r <= cls_desc;
    end
  end

endmodule

/* hw/rtl/clns_queue.sv */
module clns_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  clns_pkg::desc_t wr_desc,
  output logic            valid,
  input  logic            pop,
  output clns_pkg::desc_t rd_desc
);
  import clns_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CNT_MAX);
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_desc = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

/* hw/rtl/clns_back.sv */
module clns_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  clns_pkg::desc_t q_desc,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [3:0]      out_data_nibble,
  output logic            out_rs,
  output logic            out_enable,
  output logic [15:0]     out_hold_us,
  output logic            out_last
);
  import clns_pkg::*;

  logic       ov_r, ov_nxt;
  seg_t       seg_r;
  seg_t       seg;
  logic [5:0] step_r, step_nxt;
  logic [3:0] cur_nib_r, cur_nib_nxt;
  logic       load;
  logic [2:0] char_step;

  assign char_step = 3'(step_r - 6'd1);

  // Segment for the current step of the request at the queue head
  always_comb begin
    unique case (q_desc.kind)
      KIND_INIT: seg = init_seg(step_r);
      KIND_CHAR: begin
        if (step_r == 6'd0) begin
          // raise RS with the previous nibble still on the bus
          seg.nibble  = cur_nib_r;
          seg.rs      = 1'b1;
          seg.enable  = 1'b0;
          seg.hold_us = EN_US;
          seg.last    = 1'b0;
        end else if (step_r == CHAR_LAST_STEP) begin
          // drop RS, low nibble stays
          seg.nibble  = q_desc.data_byte[3:0];
          seg.rs      = 1'b0;
          seg.enable  = 1'b0;
          seg.hold_us = ZERO_US;
          seg.last    = 1'b1;
        end else begin
          seg = byte_seg(char_step, q_desc.data_byte, 1'b1);
        end
      end
      default: begin
        seg      = byte_seg(step_r[2:0], q_desc.data_byte, 1'b0);
        seg.last = (step_r == BYTE_LAST_STEP);
      end
    endcase
  end

  // Output register advances whenever a request is waiting and the register is free or being taken
  assign load  = q_valid && (!ov_r || out_pop);
  assign q_pop = load && seg.last;

  always_comb begin
    ov_nxt      = ov_r;
    step_nxt    = step_r;
    cur_nib_nxt = cur_nib_r;
    if (out_pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    if (load) begin
      ov_nxt   = 1'b1;
      step_nxt = seg.last ? 6'd0 : step_r + 6'd1;
      if (seg.last) begin
        cur_nib_nxt = (q_desc.kind == KIND_INIT) ? INIT_END_NIBBLE
                                                 : q_desc.data_byte[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r      <= 1'b0;
      step_r    <= '0;
      cur_nib_r <= '0;
    end else begin
      ov_r      <= ov_nxt;
      step_r    <= step_nxt;
      cur_nib_r <= cur_nib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg_r <= seg;
    end
  end

  assign out_empty       = !ov_r;
  assign out_data_nibble = seg_r.nibble;
  assign out_rs          = seg_r.rs;
  assign out_enable      = seg_r.enable;
  assign out_hold_us     = seg_r.hold_us;
  assign out_last        = seg_r.last;

endmodule

/* hw/rtl/char_lcd_nibble_sequencer_top.sv */
// First segment of a request reaches out_ via the holding stage, queue and output register.
// Throughput: one segment per cycle while out_pop takes each; init is 37 segments, command and
// cursor 6, character 8, emitted by the back sequencer into its output register.
// Requests queue ahead of the sequencer (holding stage plus QUEUE_DEPTH entries).
// Reset (rst_n low, synchronous) empties both sides and clears the bus nibble to zero.
module char_lcd_nibble_sequencer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_value,
  input  logic        in_row,
  input  logic [5:0]  in_column,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_data_nibble,
  output logic        out_rs,
  output logic        out_enable,
  output logic [15:0] out_hold_us,
  output logic        out_last
);
  import clns_pkg::*;

  logic  q_push, q_full, q_valid, q_pop;
  desc_t wr_desc, rd_desc;

  // Accept and classify
  clns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_cmd    (in_cmd),
    .in_value  (in_value),
    .in_row    (in_row),
    .in_column (in_column),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_desc    (wr_desc)
  );

  // Request queue between front and back
  clns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_desc (wr_desc),
    .valid   (q_valid),
    .pop     (q_pop),
    .rd_desc (rd_desc)
  );

  // Segment sequencer
  clns_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_desc          (rd_desc),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_data_nibble (out_data_nibble),
    .out_rs          (out_rs),
    .out_enable      (out_enable),
    .out_hold_us     (out_hold_us),
    .out_last        (out_last)
  );

endmodule

/* tb/tb_top.sv */
module tb_top;
  import clns_pkg::*;

  // One pin segment on the LCD bus
  typedef struct packed {
    logic [3:0]  nib;
    logic        rs;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } lcd_seg_t;

  // One row of the directed table; known_first marks a typed-in first segment
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] value;
    logic       row;
    logic [5:0] column;
    logic       known_first;
    lcd_seg_t   first;
  } lcd_req_t;

  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 280;
  localparam int CALM_ITEMS   = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [1:0]  in_cmd = CMD_INIT;
  logic [7:0]  in_value = 8'h00;
  logic        in_row = 1'b0;
  logic [5:0]  in_column = 6'd0;
  logic        out_pop = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [3:0]  out_data_nibble;
  logic        out_rs;
  logic        out_enable;
  logic [15:0] out_hold_us;
  logic        out_last;

  lcd_seg_t    expected_segs[$];
  logic [3:0]  bus_nibble = 4'h0;
  int          err_count = 0;
  bit          calm = 1'b0;
  int          pop_stall = 0;
  int          idle_cycles = 0;
  lcd_req_t    dir_tbl [NUM_DIRECTED];

  char_lcd_nibble_sequencer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .in_row          (in_row),
    .in_column       (in_column),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_data_nibble (out_data_nibble),
    .out_rs          (out_rs),
    .out_enable      (out_enable),
    .out_hold_us     (out_hold_us),
    .out_last        (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Segment predictor
  // ---------------------------------------------------------------
  function automatic void emit_seg(logic [3:0] nib, logic rs, logic en, logic [15:0] hold);
    lcd_seg_t s;
    s = '{nib: nib, rs: rs, en: en, hold: hold, last: 1'b0};
    expected_segs.push_back(s);
  endfunction

  // trailing delay goes onto the last segment of the step
  function automatic void stretch_tail(logic [15:0] us);
    lcd_seg_t s;
    s = expected_segs[$];
    s.hold = s.hold + us;
    expected_segs[$] = s;
  endfunction

  function automatic void emit_nibble(logic [3:0] nib, logic rs);
    bus_nibble = nib;
    emit_seg(nib, rs, 1'b0, EN_US);
    emit_seg(nib, rs, 1'b1, EN_US);
    emit_seg(nib, rs, 1'b0, EN_US);
  endfunction

  function automatic void emit_byte(logic [7:0] b, logic rs);
    emit_nibble(b[7:4], rs);
    emit_nibble(b[3:0], rs);
  endfunction

  function automatic void predict_segments(lcd_req_t req);
    lcd_seg_t s;
    logic [7:0] addr;
    int base;
    base = expected_segs.size();
    unique case (req.cmd)
      CMD_INIT: begin
        bus_nibble = 4'h0;
        emit_seg(4'h0, 1'b0, 1'b0, POWERUP_US);
        // three wake-up nibbles, then switch to 4-bit mode
        repeat (3) begin
          emit_nibble(4'h3, 1'b0);
          stretch_tail(16'd200);
        end
        emit_nibble(4'h2, 1'b0);
        stretch_tail(16'd40);
        emit_byte(8'h28, 1'b0);
        stretch_tail(16'd40);
        emit_byte(8'h0C, 1'b0);
        stretch_tail(16'd40);
        emit_byte(8'h06, 1'b0);
        stretch_tail(16'd40);
        emit_byte(8'h0F, 1'b0);
        stretch_tail(16'd2000);
      end
      CMD_BYTE: emit_byte(req.value, 1'b0);
      CMD_CHAR: begin
        // RS rises on the old nibble, drops on the new low nibble
        emit_seg(bus_nibble, 1'b1, 1'b0, EN_US);
        emit_byte(req.value, 1'b1);
        emit_seg(bus_nibble, 1'b0, 1'b0, 16'd0);
      end
      default: begin
        addr = req.row ? (8'h40 + {2'b00, req.column}) : {2'b00, req.column};
        emit_byte(8'h80 | addr, 1'b0);
      end
    endcase
    s = expected_segs[$];
    s.last = 1'b1;
    expected_segs[$] = s;
    if (req.known_first)
      expected_segs[base] = req.first;
  endfunction

  // ---------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------
  task automatic push_request(lcd_req_t req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_cmd    <= req.cmd;
    in_value  <= req.value;
    in_row    <= req.row;
    in_column <= req.column;
    do @(posedge clk); while (in_full);
    predict_segments(req);
  endtask

  function automatic lcd_req_t random_request();
    lcd_req_t req;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       req.cmd = CMD_INIT;
    else if (pick < 38) req.cmd = CMD_BYTE;
    else if (pick < 70) req.cmd = CMD_CHAR;
    else                req.cmd = CMD_CURSOR;
    req.value  = 8'($urandom_range(0, 255));
    req.row    = 1'($urandom_range(0, 1));
    // mostly real columns, some past the visible range
    req.column = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 39))
                                             : 6'($urandom_range(40, 63));
    req.known_first = 1'b0;
    req.first = '0;
    return req;
  endfunction

  initial begin
    // cmd, value, row, column, typed first segment
    dir_tbl[0]  = '{CMD_CHAR,   8'h41, 1'b0, 6'd0,  1'b1, '{4'h0, 1'b1, 1'b0, 16'd5, 1'b0}};
    dir_tbl[1]  = '{CMD_INIT,   8'h00, 1'b0, 6'd0,  1'b1, '{4'h0, 1'b0, 1'b0, 16'd40000, 1'b0}};
    dir_tbl[2]  = '{CMD_CHAR,   8'h00, 1'b0, 6'd0,  1'b1, '{4'hF, 1'b1, 1'b0, 16'd5, 1'b0}};
    dir_tbl[3]  = '{CMD_BYTE,   8'h00, 1'b0, 6'd0,  1'b1, '{4'h0, 1'b0, 1'b0, 16'd5, 1'b0}};
    dir_tbl[4]  = '{CMD_BYTE,   8'hFF, 1'b0, 6'd0,  1'b1, '{4'hF, 1'b0, 1'b0, 16'd5, 1'b0}};
    dir_tbl[5]  = '{CMD_CHAR,   8'hFF, 1'b0, 6'd0,  1'b0, '0};
    dir_tbl[6]  = '{CMD_CHAR,   8'h80, 1'b0, 6'd0,  1'b0, '0};
    dir_tbl[7]  = '{CMD_CURSOR, 8'h00, 1'b0, 6'd0,  1'b1, '{4'h8, 1'b0, 1'b0, 16'd5, 1'b0}};
    dir_tbl[8]  = '{CMD_CURSOR, 8'h00, 1'b1, 6'd0,  1'b1, '{4'hC, 1'b0, 1'b0, 16'd5, 1'b0}};
    dir_tbl[9]  = '{CMD_CURSOR, 8'h00, 1'b1, 6'd39, 1'b0, '0};
    dir_tbl[10] = '{CMD_CURSOR, 8'h00, 1'b0, 6'd39, 1'b0, '0};
    dir_tbl[11] = '{CMD_CURSOR, 8'h00, 1'b1, 6'd63, 1'b1, '{4'hF, 1'b0, 1'b0, 16'd5, 1'b0}};
    dir_tbl[12] = '{CMD_CURSOR, 8'h00, 1'b0, 6'd63, 1'b0, '0};
    dir_tbl[13] = '{CMD_CURSOR, 8'h00, 1'b0, 6'd40, 1'b0, '0};
    // unused fields set to their extremes
    dir_tbl[14] = '{CMD_BYTE,   8'h5A, 1'b1, 6'd63, 1'b0, '0};
    dir_tbl[15] = '{CMD_CHAR,   8'hA5, 1'b1, 6'd63, 1'b0, '0};
    dir_tbl[16] = '{CMD_CURSOR, 8'hFF, 1'b1, 6'd21, 1'b0, '0};
    dir_tbl[17] = '{CMD_INIT,   8'hFF, 1'b1, 6'd63, 1'b0, '0};
    dir_tbl[18] = '{CMD_BYTE,   8'h01, 1'b0, 6'd0,  1'b0, '0};
    dir_tbl[19] = '{CMD_CHAR,   8'h7F, 1'b0, 6'd0,  1'b0, '0};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) push_request(dir_tbl[i]);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - CALM_ITEMS) calm = 1'b1;
      push_request(random_request());
    end
    in_push <= 1'b0;

    // drain, then keep watching for stray segments
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------
  // Segment checker and pop pacing
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    lcd_seg_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_segs.size() == 0) begin
        $display("%0t: unexpected segment: expected none, actual nib=%h rs=%b en=%b",
                 $time, out_data_nibble, out_rs, out_enable);
        $display("%0t: unexpected segment: actual hold=%0d last=%b",
                 $time, out_hold_us, out_last);
        err_count++;
      end else begin
        want = expected_segs.pop_front();
        if (out_data_nibble !== want.nib) begin
          $display("%0t: data_nibble: expected %h, actual %h", $time, want.nib, out_data_nibble);
          err_count++;
        end
        if (out_rs !== want.rs) begin
          $display("%0t: rs: expected %b, actual %b", $time, want.rs, out_rs);
          err_count++;
        end
        if (out_enable !== want.en) begin
          $display("%0t: enable: expected %b, actual %b", $time, want.en, out_enable);
          err_count++;
        end
        if (out_hold_us !== want.hold) begin
          $display("%0t: hold_us: expected %0d, actual %0d", $time, want.hold, out_hold_us);
          err_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last: expected %b, actual %b", $time, want.last, out_last);
          err_count++;
        end
      end
    end
    // stall the reader in short bursts, each begun only while pop is high; none once calm
    if (calm) begin
      out_pop <= 1'b1;
    end else if (pop_stall > 0) begin
      pop_stall--;
      out_pop <= 1'b0;
    end else if (out_pop && $urandom_range(0, 4) == 0) begin
      pop_stall = $urandom_range(0, 2);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

endmodule
